@@ rtl/assert_macros.svh @@
// Assertion macros shared by the decoder RTL.
// Assumes a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define XMSD_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Check a plain condition on every clock edge outside reset.
`define XMSD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

`endif

@@ rtl/xmsd_pkg.sv @@
// Types and constants for the XOR-masked string decoder.
// No dependencies; used by xor_masked_string_decoder_core.
`timescale 1ns / 1ps

package xmsd_pkg;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_LEN32  = 3'd1,
    PH_NARROW = 3'd2,
    PH_WLOW   = 3'd3,
    PH_WHIGH  = 3'd4
  } phase_t;

  localparam logic [15:0] WIDE_MASK0     = 16'hAAAA;
  localparam logic [7:0]  NARROW_MASK0   = 8'hAA;
  localparam logic [7:0]  LEN_ESC_WIDE   = 8'h7F;
  localparam logic [7:0]  LEN_ESC_NARROW = 8'h80;

endpackage

@@ rtl/xor_masked_string_decoder_core.sv @@
// XOR-masked string decoder: length-prefixed 8/16-bit strings, one byte a beat.
// Depends on xmsd_pkg and assert_macros.svh.
//
//   channel  | dir | tdata                            | tlast      | tuser
//   in_      | in  | [7:0] data_byte, [15:8] key_byte | -          | start_req
//   out_     | out | [15:0] char_code                 | last       | empty_res
//
// One byte per clock sustained while out_ is not stalled. A beat lands in
// the input stage, is decoded by combinational logic and its result, if any,
// goes to the output register. The input stage advances whenever the output
// register is empty or being drained, so a stall on out_ backs up into
// in_tready with no bubble.
// Reset (rst_n low, synchronous) returns to expecting a length prefix.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xor_masked_string_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [15:8] key_byte
  input  logic        in_tuser,   // [0] start_req
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] char_code
  output logic        out_tlast,
  output logic        out_tuser   // [0] empty_res
);

  // input stage
  logic       s_vld_r;
  logic [7:0] s_data_r;
  logic [7:0] s_key_r;
  logic       s_start_r;

  // decoder state
  xmsd_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] len_acc_r, len_acc_nxt;
  logic [1:0]  len_cnt_r, len_cnt_nxt;
  logic [30:0] rem_r, rem_nxt;
  logic        wide_r, wide_nxt;
  logic [15:0] mask_r, mask_nxt;
  logic [7:0]  low_hold_r, low_hold_nxt;

  // output register
  logic        out_vld_r;
  logic [15:0] out_code_r;
  logic        out_last_r;
  logic        out_empty_r;

  logic        out_free;
  logic        advance;
  logic        emit;
  logic [15:0] emit_code;
  logic        emit_last;
  logic        emit_empty;
  logic [7:0]  dk;
  logic [31:0] acc_upd;
  logic [7:0]  neg_len;

  assign out_free  = !out_vld_r || out_tready;
  assign advance   = s_vld_r && out_free;
  assign in_tready = !s_vld_r || out_free;

  assign dk      = s_data_r ^ s_key_r;
  assign neg_len = 8'(~s_data_r + 8'd1);

  always_comb begin
    acc_upd = len_acc_r;
    acc_upd[{len_cnt_r, 3'b000} +: 8] = len_acc_r[{len_cnt_r, 3'b000} +: 8] | s_data_r;
  end

  always_comb begin
    phase_nxt    = phase_r;
    len_acc_nxt  = len_acc_r;
    len_cnt_nxt  = len_cnt_r;
    rem_nxt      = rem_r;
    wide_nxt     = wide_r;
    mask_nxt     = mask_r;
    low_hold_nxt = low_hold_r;
    emit         = 1'b0;
    emit_code    = 16'h0000;
    emit_last    = 1'b0;
    emit_empty   = 1'b0;

    if (s_start_r || phase_r == xmsd_pkg::PH_PREFIX) begin
      len_acc_nxt  = 32'h0;
      len_cnt_nxt  = 2'd0;
      low_hold_nxt = 8'h00;
      if (s_data_r == 8'h00) begin
        phase_nxt  = xmsd_pkg::PH_PREFIX;
        emit       = 1'b1;
        emit_last  = 1'b1;
        emit_empty = 1'b1;
      end else if (!s_data_r[7]) begin
        wide_nxt = 1'b1;
        if (s_data_r == xmsd_pkg::LEN_ESC_WIDE) begin
          phase_nxt = xmsd_pkg::PH_LEN32;
        end else begin
          rem_nxt   = {23'h0, s_data_r};
          mask_nxt  = xmsd_pkg::WIDE_MASK0;
          phase_nxt = xmsd_pkg::PH_WLOW;
        end
      end else begin
        wide_nxt = 1'b0;
        if (s_data_r == xmsd_pkg::LEN_ESC_NARROW) begin
          phase_nxt = xmsd_pkg::PH_LEN32;
        end else begin
          rem_nxt   = {23'h0, neg_len};
          mask_nxt  = {8'h00, xmsd_pkg::NARROW_MASK0};
          phase_nxt = xmsd_pkg::PH_NARROW;
        end
      end
    end else begin
      unique case (phase_r)
        xmsd_pkg::PH_LEN32: begin
          len_acc_nxt = acc_upd;
          if (len_cnt_r == 2'd3) begin
            len_cnt_nxt = 2'd0;
            if (acc_upd == 32'h0 || acc_upd[31]) begin
              phase_nxt  = xmsd_pkg::PH_PREFIX;
              emit       = 1'b1;
              emit_last  = 1'b1;
              emit_empty = 1'b1;
            end else begin
              rem_nxt = acc_upd[30:0];
              if (wide_r) begin
                mask_nxt  = xmsd_pkg::WIDE_MASK0;
                phase_nxt = xmsd_pkg::PH_WLOW;
              end else begin
                mask_nxt  = {8'h00, xmsd_pkg::NARROW_MASK0};
                phase_nxt = xmsd_pkg::PH_NARROW;
              end
            end
          end else begin
            len_cnt_nxt = len_cnt_r + 2'd1;
          end
        end
        xmsd_pkg::PH_NARROW: begin
          emit      = 1'b1;
          emit_code = {8'h00, dk ^ mask_r[7:0]};
          mask_nxt  = {8'h00, 8'(mask_r[7:0] + 8'd1)};
          rem_nxt   = rem_r - 31'd1;
          emit_last = (rem_r == 31'd1);
          if (rem_r == 31'd1) begin
            phase_nxt = xmsd_pkg::PH_PREFIX;
          end
        end
        xmsd_pkg::PH_WLOW: begin
          low_hold_nxt = dk;
          phase_nxt    = xmsd_pkg::PH_WHIGH;
        end
        xmsd_pkg::PH_WHIGH: begin
          emit      = 1'b1;
          emit_code = {dk, low_hold_r} ^ mask_r;
          mask_nxt  = mask_r + 16'd1;
          rem_nxt   = rem_r - 31'd1;
          emit_last = (rem_r == 31'd1);
          phase_nxt = (rem_r == 31'd1) ? xmsd_pkg::PH_PREFIX : xmsd_pkg::PH_WLOW;
        end
        default: begin
          phase_nxt = xmsd_pkg::PH_PREFIX;
        end
      endcase
    end
  end

  // input stage: take a beat whenever the stage is empty or moving on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (in_tready) begin
      s_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s_data_r  <= in_tdata[7:0];
      s_key_r   <= in_tdata[15:8];
      s_start_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= xmsd_pkg::PH_PREFIX;
      len_acc_r  <= 32'h0;
      len_cnt_r  <= 2'd0;
      rem_r      <= 31'h0;
      wide_r     <= 1'b0;
      mask_r     <= 16'h0;
      low_hold_r <= 8'h00;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      len_acc_r  <= len_acc_nxt;
      len_cnt_r  <= len_cnt_nxt;
      rem_r      <= rem_nxt;
      wide_r     <= wide_nxt;
      mask_r     <= mask_nxt;
      low_hold_r <= low_hold_nxt;
    end
  end

  // output register: load on a result, drop valid once drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_code_r  <= emit_code;
      out_last_r  <= emit_last;
      out_empty_r <= emit_empty;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_code_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_empty_r;

  `XMSD_ASSERT_IMPL(a_empty_shape, out_vld_r && out_empty_r,
                    out_code_r == 16'h0000 && out_last_r, "empty result carries a char")
  `XMSD_ASSERT_IMPL(a_whigh_wide, phase_r == xmsd_pkg::PH_WHIGH, wide_r,
                    "wide high byte phase without wide chars")
  `XMSD_ASSERT_IMPL(a_narrow_mask, phase_r == xmsd_pkg::PH_NARROW, mask_r[15:8] == 8'h00,
                    "narrow mask overflowed into high byte")
  `XMSD_ASSERT_IMPL(a_payload_rem,
                    phase_r == xmsd_pkg::PH_NARROW || phase_r == xmsd_pkg::PH_WLOW ||
                    phase_r == xmsd_pkg::PH_WHIGH,
                    rem_r != 31'h0, "payload phase with no chars left")
  `XMSD_ASSERT_IMPL(a_stall_src, !in_tready, s_vld_r && out_vld_r && !out_tready,
                    "input stalled without a blocked result")

endmodule
